FILE: src/md5_pkg.sv
`timescale 1ns / 1ps
package md5_pkg;

   localparam int unsigned BlockWords = 16;
   localparam int unsigned Steps = 64;
   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
   } comp_ctl_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      begin
         unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
         endcase
         return k;
      end
   endfunction

   function automatic logic [4:0] rot_amount(input logic [3:0] sel);
      logic [4:0] s;
      begin
         unique case (sel)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
         endcase
         return s;
      end
   endfunction

endpackage

FILE: src/md5_round.sv
`timescale 1ns / 1ps
module md5_round (
   input  logic                clock,
   input  logic                reset,
   input  md5_pkg::comp_ctl_type ctl_in,
   input  logic [31:0]         chain_a,
   input  logic [31:0]         chain_b,
   input  logic [31:0]         chain_c,
   input  logic [31:0]         chain_d,
   output logic [3:0]          word_sel,
   input  logic [31:0]         word_data,
   output logic                busy,
   output logic [31:0]         res_a,
   output logic [31:0]         res_b,
   output logic [31:0]         res_c,
   output logic [31:0]         res_d
);
   import md5_pkg::*;

   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [31:0] f, sum, rot;
   logic [4:0]  sh;
   logic [1:0]  rnd;

   assign rnd = step_ff[5:4];

   // One MD5 step per cycle; the message schedule index is formed from the step.
   always_comb begin
      unique case (rnd)
         2'd0: begin
            f = (b_ff & c_ff) | (~b_ff & d_ff);
            word_sel = step_ff[3:0];
         end
         2'd1: begin
            f = (b_ff & d_ff) | (c_ff & ~d_ff);
            word_sel = 4'(step_ff * 3'd5 + 6'd1);
         end
         2'd2: begin
            f = b_ff ^ c_ff ^ d_ff;
            word_sel = 4'(step_ff * 2'd3 + 6'd5);
         end
         default: begin
            f = c_ff ^ (b_ff | ~d_ff);
            word_sel = 4'(step_ff * 3'd7);
         end
      endcase
      sh  = rot_amount({rnd, step_ff[1:0]});
      sum = f + a_ff + round_const(step_ff) + word_data;
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (ctl_in.start) begin
         a_in = chain_a; b_in = chain_b; c_in = chain_c; d_in = chain_d;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in = d_ff; d_in = c_ff; c_in = b_ff;
         b_in = b_ff + rot;
         step_in = step_ff + 6'd1;
         if (step_ff == 6'(Steps - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
   end

   assign busy  = busy_ff;
   assign res_a = a_ff;
   assign res_b = b_ff;
   assign res_c = c_ff;
   assign res_d = d_ff;
endmodule

FILE: src/md5_message_digest.sv
`timescale 1ns / 1ps
// A byte that fills a block starts a compression, and input waits while the
// one round unit runs 64 steps at one per cycle. End of message adds padding
// at one byte per cycle outside compressions, up to two compressions, and four
// result beats. Reset is synchronous and restores the initial chaining values,
// a zero bit count and byte position; the block buffer is not cleared.
module md5_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tuser,  // byte_valid
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // digest_word
   output logic [1:0]  rsp_tuser,  // word_index
   output logic        rsp_tlast   // last_word
);
   import md5_pkg::*;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [31:0] blk_ff [BlockWords];
   logic [63:0] len_ff, len_in, lat_ff, lat_in;
   logic [5:0]  pos_ff, pos_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  oidx_ff, oidx_in;
   logic        wr_en;
   logic [7:0]  wr_byte;
   logic [3:0]  word_sel;
   logic        busy, busy_q_ff;
   comp_ctl_type ctl;
   logic [31:0] ra, rb, rc, rd;
   logic        accept, comp_done;

   assign accept = req_tvalid && req_tready;
   assign comp_done = busy_q_ff && !busy;

   md5_round u_round (
      .clock(clock), .reset(reset), .ctl_in(ctl),
      .chain_a(h_ff[0]), .chain_b(h_ff[1]), .chain_c(h_ff[2]), .chain_d(h_ff[3]),
      .word_sel(word_sel), .word_data(blk_ff[word_sel]), .busy(busy),
      .res_a(ra), .res_b(rb), .res_c(rc), .res_d(rd)
   );

   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      h_in = h_ff; len_in = len_ff; lat_in = lat_ff;
      pos_in = pos_ff; cnt_in = cnt_ff; oidx_in = oidx_ff;
      wr_en = 1'b0; wr_byte = req_tdata;
      ctl.start = 1'b0;
      req_tready = 1'b0; rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               lat_in = len_ff + (req_tuser ? 64'd8 : 64'd0);
               len_in = lat_in;
               ret_in = req_tlast ? ST_PAD : ST_IDLE;
               if (req_tuser) begin
                  wr_en = 1'b1;
                  pos_in = pos_ff + 6'd1;
                  if (pos_ff == 6'h3f) begin
                     ctl.start = 1'b1;
                     state_in = ST_COMP;
                  end else if (req_tlast) state_in = ST_PAD;
               end else if (req_tlast) state_in = ST_PAD;
               cnt_in = '0;
            end
         end
         ST_COMP: begin
            if (comp_done) begin
               h_in[0] = h_ff[0] + ra; h_in[1] = h_ff[1] + rb;
               h_in[2] = h_ff[2] + rc; h_in[3] = h_ff[3] + rd;
               state_in = ret_ff;
            end
         end
         ST_PAD: begin
            // First byte of the padding is 0x80, then zeros up to the length field.
            wr_en = 1'b1;
            wr_byte = (cnt_ff == 3'd0) ? PadByte : 8'h00;
            cnt_in = 3'd1;
            pos_in = pos_ff + 6'd1;
            if (pos_in == LenStart) begin
               state_in = ST_LEN;
               cnt_in = '0;
            end
            if (pos_ff == 6'h3f) begin
               ctl.start = 1'b1;
               ret_in = (pos_in == LenStart) ? ST_LEN : ST_PAD;
               state_in = ST_COMP;
            end
         end
         ST_LEN: begin
            wr_en = 1'b1;
            wr_byte = lat_ff[8*cnt_ff +: 8];
            cnt_in = cnt_ff + 3'd1;
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'h3f) begin
               ctl.start = 1'b1;
               ret_in = ST_OUT;
               state_in = ST_COMP;
               oidx_in = '0;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               oidx_in = oidx_ff + 2'd1;
               if (oidx_ff == 2'd3) begin
                  state_in = ST_IDLE;
                  h_in[0] = InitA; h_in[1] = InitB; h_in[2] = InitC; h_in[3] = InitD;
                  len_in = '0;
                  pos_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = h_ff[oidx_ff];
   assign rsp_tuser = oidx_ff;
   assign rsp_tlast = (oidx_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         h_ff[0] <= InitA; h_ff[1] <= InitB; h_ff[2] <= InitC; h_ff[3] <= InitD;
         len_ff <= '0;
         pos_ff <= '0;
         cnt_ff <= '0;
         oidx_ff <= '0;
         busy_q_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         h_ff <= h_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         oidx_ff <= oidx_in;
         busy_q_ff <= busy;
      end
      lat_ff <= lat_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) blk_ff[pos_ff[5:2]][8*pos_ff[1:0] +: 8] <= wr_byte;
   end

   a_out_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_OUT)
      else $error("result beat outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("input accepted while round unit busy");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> state_ff == ST_IDLE && pos_ff == 6'd0)
      else $error("state not restored after digest");
endmodule
